>>> hw/rtl/wfmb_pkg.sv
// Package: shared types, codes and constants for the window fill and mono blit block.
`default_nettype none
package wfmb_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_START_FILL = 2'd0;
  localparam logic [1:0] FUNC_START_BLIT = 2'd1;
  localparam logic [1:0] FUNC_BITMAP     = 2'd2;
  localparam logic [1:0] FUNC_TICK       = 2'd3;

  // Draw mode codes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_FILL = 2'd1;
  localparam logic [1:0] MODE_BLIT = 2'd2;

  // Job kinds handed to the serialiser
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Register indexes (byte address 4*i)
  localparam logic [2:0] REG_FG_COLOR  = 3'd0;
  localparam logic [2:0] REG_BG_COLOR  = 3'd1;
  localparam logic [2:0] REG_COLUMN    = 3'd2;
  localparam logic [2:0] REG_PAGE      = 3'd3;
  localparam logic [2:0] REG_WRITE     = 3'd4;
  localparam logic [2:0] REG_NOP       = 3'd5;

  // Byte positions within the window sequence
  localparam logic [4:0] POS_COLUMN_CMD = 5'd0;
  localparam logic [4:0] POS_X0_HI      = 5'd1;
  localparam logic [4:0] POS_X0_LO      = 5'd2;
  localparam logic [4:0] POS_X1_HI      = 5'd3;
  localparam logic [4:0] POS_X1_LO      = 5'd4;
  localparam logic [4:0] POS_PAGE_CMD   = 5'd5;
  localparam logic [4:0] POS_Y0_HI      = 5'd6;
  localparam logic [4:0] POS_Y0_LO      = 5'd7;
  localparam logic [4:0] POS_Y1_HI      = 5'd8;
  localparam logic [4:0] POS_Y1_LO      = 5'd9;
  localparam logic [4:0] POS_WRITE_CMD  = 5'd10;
  localparam logic [4:0] START_BYTES    = 5'd11;

  localparam int PIXELS_PER_BYTE = 8;

  typedef struct packed {
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic [7:0]  column_cmd_code;
    logic [7:0]  page_cmd_code;
    logic [7:0]  write_cmd_code;
    logic [7:0]  nop_cmd_code;
  } cfg_t;

  // One decoded job: the bytes it expands into are fully set by these fields and the config registers
  typedef struct packed {
    logic        kind;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [7:0]  bits;
    logic [3:0]  npix;
    logic        nop;
  } job_t;

endpackage
`default_nettype wire

>>> hw/rtl/wfmb_if.sv
// Interfaces: input item channel and result byte channel.
`default_nettype none
interface wfmb_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] width;
  logic [15:0] height;
  logic [7:0]  bitmap_byte;
  modport source (output valid, func, pos_x, pos_y, width, height, bitmap_byte,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, width, height, bitmap_byte,
                output ready);
endinterface

interface wfmb_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       is_command;
  logic       last;
  logic       draw_done;
  modport source (output valid, bus_byte, is_command, last, draw_done, input ready);
  modport sink (input valid, bus_byte, is_command, last, draw_done, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/window_fill_and_mono_blit.sv
// Top level: window fill and monochrome bitmap colour-expansion blit front end.
// Usage
//   items   : input channel (valid/ready). func selects start fill, start blit,
//             bitmap byte or fill tick; a transfer happens when valid and ready are high.
//   results : output channel, one controller bus byte per transfer, with is_command,
//             last (final byte caused by an item) and draw_done (on the closing NOP).
//   APB     : six registers at byte addresses 0..20 (colours, command codes);
//             write only while the block is idle.
// When the unit is free, an item's job is held in the pending job register and then
//   loaded into the serialiser's current-job register before its first byte is offered.
//   The output byte serialiser sets the pace: a start item gives 11 bytes
//   (12 with the NOP), a fill tick 3 or 4, a bitmap byte 3*pixels (+1 with the NOP),
//   up to 25; one decoded job waits in a pending register so the next item is taken
//   while the current one is still going out.
// Items that match no current draw are taken and give no bytes.
// Reset (synchronous, rst high) clears the draw state to idle, the pixel counter to
//   zero, empties the pending and serialiser stages and restores register defaults.
// Receiver stall: the current byte holds; once the pending job is full the items
//   channel drops ready until the serialiser takes it.
`default_nettype none
module window_fill_and_mono_blit
  import wfmb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  wfmb_item_if.sink        items,
  wfmb_result_if.source    results,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic pop;

  // Register bank
  wfmb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Decode items into jobs
  wfmb_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .pop       (pop),
    .job_valid (job_valid),
    .job       (job)
  );

  // Expand jobs into bus bytes
  wfmb_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .results   (results)
  );

endmodule
`default_nettype wire

>>> hw/rtl/wfmb_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module wfmb_cfg
  import wfmb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Write on the access cycle of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color        <= 24'hFFFFFF;
      cfg.bg_color        <= 24'h000000;
      cfg.column_cmd_code <= 8'd42;
      cfg.page_cmd_code   <= 8'd43;
      cfg.write_cmd_code  <= 8'd44;
      cfg.nop_cmd_code    <= 8'd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_FG_COLOR: cfg.fg_color        <= pwdata[23:0];
        REG_BG_COLOR: cfg.bg_color        <= pwdata[23:0];
        REG_COLUMN:   cfg.column_cmd_code <= pwdata[7:0];
        REG_PAGE:     cfg.page_cmd_code   <= pwdata[7:0];
        REG_WRITE:    cfg.write_cmd_code  <= pwdata[7:0];
        REG_NOP:      cfg.nop_cmd_code    <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_FG_COLOR: prdata = {8'd0, cfg.fg_color};
      REG_BG_COLOR: prdata = {8'd0, cfg.bg_color};
      REG_COLUMN:   prdata = {24'd0, cfg.column_cmd_code};
      REG_PAGE:     prdata = {24'd0, cfg.page_cmd_code};
      REG_WRITE:    prdata = {24'd0, cfg.write_cmd_code};
      REG_NOP:      prdata = {24'd0, cfg.nop_cmd_code};
      default:      prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/wfmb_decode.sv
// Item decoder: draw state, pixel counter and the pending job register.
`default_nettype none
module wfmb_decode
  import wfmb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  wfmb_item_if.sink   items,
  input  wire logic   pop,
  output logic        job_valid,
  output job_t        job
);

  logic [31:0] pixels_left;
  logic [31:0] pixels_left_next;
  logic [1:0]  draw_mode;
  logic [1:0]  draw_mode_next;
  logic        take;
  logic        has_job;
  job_t        job_next;
  logic [31:0] area;
  logic [3:0]  blit_pix;

  assign items.ready = !job_valid || pop;
  assign take        = items.valid && items.ready;
  assign area        = {16'd0, items.width} * {16'd0, items.height};
  assign blit_pix    = (pixels_left >= 32'(PIXELS_PER_BYTE)) ? 4'(PIXELS_PER_BYTE)
                                                              : pixels_left[3:0];

  // Work out the job and the next draw state for the offered item
  always_comb begin
    pixels_left_next = pixels_left;
    draw_mode_next   = draw_mode;
    has_job          = 1'b0;
    job_next.kind    = KIND_START;
    job_next.x0      = items.pos_x;
    job_next.x1      = items.pos_x + items.width - 16'd1;
    job_next.y0      = items.pos_y;
    job_next.y1      = items.pos_y + items.height - 16'd1;
    job_next.bits    = items.bitmap_byte;
    job_next.npix    = blit_pix;
    job_next.nop     = 1'b0;
    case (items.func)
      FUNC_START_FILL, FUNC_START_BLIT: begin
        has_job          = 1'b1;
        job_next.nop     = (items.width == 16'd0) || (items.height == 16'd0);
        pixels_left_next = area;
        if (job_next.nop) begin
          draw_mode_next = MODE_IDLE;
        end else if (items.func == FUNC_START_FILL) begin
          draw_mode_next = MODE_FILL;
        end else begin
          draw_mode_next = MODE_BLIT;
        end
      end
      FUNC_TICK: begin
        if (draw_mode == MODE_FILL) begin
          has_job          = 1'b1;
          job_next.kind    = KIND_PIXEL;
          job_next.bits    = 8'h01;
          job_next.npix    = 4'd1;
          job_next.nop     = (pixels_left == 32'd1);
          pixels_left_next = pixels_left - 32'd1;
          if (job_next.nop) begin
            draw_mode_next = MODE_IDLE;
          end
        end
      end
      default: begin
        if (draw_mode == MODE_BLIT) begin
          has_job          = 1'b1;
          job_next.kind    = KIND_PIXEL;
          job_next.nop     = (pixels_left <= 32'(PIXELS_PER_BYTE));
          pixels_left_next = pixels_left - {28'd0, blit_pix};
          if (job_next.nop) begin
            draw_mode_next = MODE_IDLE;
          end
        end
      end
    endcase
  end

  // Advance state on every transfer; drop items that give nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left <= 32'd0;
      draw_mode   <= MODE_IDLE;
      job_valid   <= 1'b0;
    end else begin
      if (take) begin
        pixels_left <= pixels_left_next;
        draw_mode   <= draw_mode_next;
      end
      if (take && has_job) begin
        job_valid <= 1'b1;
      end else if (pop) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_job) begin
      job <= job_next;
    end
  end

  // A drawing mode always has pixels to go
  a_fill_nonempty: assert property (@(posedge clk) disable iff (rst)
    draw_mode != MODE_IDLE |-> pixels_left != 32'd0)
    else $error("drawing mode with empty pixel counter");

  // A held job stays put until taken
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    job_valid && !pop |=> job_valid && $stable(job))
    else $error("pending job lost");

  // A pixel job never carries more than one byte of pixels
  a_npix_range: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.kind == KIND_PIXEL |-> job.npix != 4'd0 &&
      job.npix <= 4'(PIXELS_PER_BYTE))
    else $error("pixel job with bad pixel count");

endmodule
`default_nettype wire

>>> hw/rtl/wfmb_serial.sv
// Serialiser: expands one job into bus bytes, one byte per cycle while the receiver is ready.
`default_nettype none
module wfmb_serial
  import wfmb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   job_valid,
  input  wire job_t   job,
  output logic        pop,
  wfmb_result_if.source results
);

  logic       busy;
  job_t       cur;
  logic [4:0] cnt;
  logic [2:0] pix;
  logic [1:0] sub;
  logic [4:0] pix_bytes;
  logic [4:0] total_m1;
  logic       at_end;
  logic       at_nop;
  logic       xfer;
  logic       fin;
  logic [23:0] colour;
  logic [7:0]  colour_byte;

  assign pix_bytes = {cur.npix, 1'b0} + {1'b0, cur.npix};
  assign total_m1  = (cur.kind == KIND_START) ? START_BYTES - 5'd1 + {4'd0, cur.nop}
                                              : pix_bytes - 5'd1 + {4'd0, cur.nop};
  assign at_end    = (cnt == total_m1);
  assign at_nop    = at_end && cur.nop;
  assign xfer      = results.valid && results.ready;
  assign fin       = xfer && at_end;
  assign pop       = job_valid && (!busy || fin);

  // Pixel colour and the byte within it
  assign colour = cur.bits[pix] ? cfg.fg_color : cfg.bg_color;
  always_comb begin
    case (sub)
      2'd0:    colour_byte = colour[23:16];
      2'd1:    colour_byte = colour[15:8];
      default: colour_byte = colour[7:0];
    endcase
  end

  // Pick the byte for the current position
  always_comb begin
    results.valid      = busy;
    results.last       = at_end;
    results.draw_done  = at_nop;
    results.is_command = at_nop;
    results.bus_byte   = cfg.nop_cmd_code;
    if (at_nop) begin
      results.bus_byte = cfg.nop_cmd_code;
    end else if (cur.kind == KIND_PIXEL) begin
      results.bus_byte = colour_byte;
    end else begin
      case (cnt)
        POS_COLUMN_CMD: begin
          results.bus_byte   = cfg.column_cmd_code;
          results.is_command = 1'b1;
        end
        POS_X0_HI: results.bus_byte = cur.x0[15:8];
        POS_X0_LO: results.bus_byte = cur.x0[7:0];
        POS_X1_HI: results.bus_byte = cur.x1[15:8];
        POS_X1_LO: results.bus_byte = cur.x1[7:0];
        POS_PAGE_CMD: begin
          results.bus_byte   = cfg.page_cmd_code;
          results.is_command = 1'b1;
        end
        POS_Y0_HI: results.bus_byte = cur.y0[15:8];
        POS_Y0_LO: results.bus_byte = cur.y0[7:0];
        POS_Y1_HI: results.bus_byte = cur.y1[15:8];
        POS_Y1_LO: results.bus_byte = cur.y1[7:0];
        POS_WRITE_CMD: begin
          results.bus_byte   = cfg.write_cmd_code;
          results.is_command = 1'b1;
        end
        default: results.bus_byte = cfg.nop_cmd_code;
      endcase
    end
  end

  // Load a new job, advance on each transfer, hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (fin) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
      cnt <= 5'd0;
      pix <= 3'd0;
      sub <= 2'd0;
    end else if (xfer) begin
      cnt <= cnt + 5'd1;
      if (sub == 2'd2) begin
        sub <= 2'd0;
        pix <= pix + 3'd1;
      end else begin
        sub <= sub + 2'd1;
      end
    end
  end

  // Position never runs past the end of the job
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= total_m1)
    else $error("byte position beyond end of job");

  // The end-of-draw marker only rides on the last byte of a job
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.draw_done |-> results.last && results.is_command)
    else $error("draw_done away from last command byte");

  // After the last transfer a fresh job starts at position zero or the unit idles
  a_restart: assert property (@(posedge clk) disable iff (rst)
    fin |=> !busy || cnt == 5'd0)
    else $error("job did not restart cleanly");

endmodule
`default_nettype wire
